@@ hdl/mqmd_pkg.sv @@
// Package for the multi-queue message deque: sizes, request and status codes,
// controller state type and the command and status bundles.
// No dependencies.
package mqmd_pkg;

    localparam int QUEUE_COUNT   = 4;
    localparam int QUEUE_DEPTH   = 16;
    localparam int MESSAGE_WIDTH = 16;

    localparam int REQ_W    = 3;
    localparam int QIN_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;
    localparam int QIDX_W   = $clog2(QUEUE_COUNT);
    localparam int POS_W    = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W   = QIDX_W + POS_W;
    localparam int MEM_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_BASE = 3'd1;

    localparam logic [REQ_W-1:0] REQ_POST_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POST_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TAKE       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL_OR_OFF = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

@@ hdl/mqmd_ctrl.sv @@
// Controller state machine for the multi-queue message deque.
// Depends on mqmd_pkg; drives the datapath through t_dp_cmd.
module mqmd_ctrl
    import mqmd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load_req = 1'b1;
                        n_state        = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/mqmd_datapath.sv @@
// Datapath of the multi-queue message deque: configuration registers, queue
// pointers and counts, the shared message store and the result register.
// Depends on mqmd_pkg; controlled by mqmd_ctrl through t_dp_cmd.
module mqmd_datapath
    import mqmd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [QIN_W-1:0]         i_queue_index,
    input  logic [MESSAGE_WIDTH-1:0] i_message_in,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [MESSAGE_WIDTH-1:0] o_message_out,
    output logic [CNT_W-1:0]         o_entry_count
);

    logic [QUEUE_COUNT-1:0] r_enable;
    logic [CNT_W-1:0]       r_cap    [QUEUE_COUNT];
    logic [POS_W-1:0]       r_rd_pos [QUEUE_COUNT];
    logic [POS_W-1:0]       r_wr_pos [QUEUE_COUNT];
    logic [CNT_W-1:0]       r_occ    [QUEUE_COUNT];

    logic [REQ_W-1:0]         r_req;
    logic [QIN_W-1:0]         r_qin;
    logic [MESSAGE_WIDTH-1:0] r_msg;

    logic [MESSAGE_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [MESSAGE_WIDTH-1:0] r_rd_data;

    logic [STATUS_W-1:0] r_res_status;
    logic [CNT_W-1:0]    r_res_count;
    logic                r_res_take;

    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_out_status;
    logic [MESSAGE_WIDTH-1:0] r_out_msg;
    logic [CNT_W-1:0]         r_out_count;

    logic                bad_index;
    logic [QIDX_W-1:0]   q;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    occ;
    logic [POS_W-1:0]    rdp;
    logic [POS_W-1:0]    wrp;
    logic [CNT_W-1:0]    wr_inc;
    logic [CNT_W-1:0]    rd_inc;
    logic [POS_W-1:0]    front_pos;
    logic                is_post;
    logic [STATUS_W-1:0] n_status;
    logic [CNT_W-1:0]    n_occ;
    logic [POS_W-1:0]    n_rdp;
    logic [POS_W-1:0]    n_wrp;
    logic                mem_we;
    logic [POS_W-1:0]    mem_wr_pos;
    logic                take_ok;
    logic                cap_sel;
    logic [QIDX_W-1:0]   cap_q;
    logic [CFG_IDX_W-1:0] cap_off;

    assign bad_index = (r_qin >= QIN_W'(QUEUE_COUNT));
    assign q         = r_qin[QIDX_W-1:0];
    assign cap       = (r_cap[q] > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : r_cap[q];
    assign occ       = r_occ[q];
    assign rdp       = r_rd_pos[q];
    assign wrp       = r_wr_pos[q];
    assign wr_inc    = {1'b0, wrp} + CNT_W'(1);
    assign rd_inc    = {1'b0, rdp} + CNT_W'(1);
    assign front_pos = (rdp == '0) ? POS_W'(cap - CNT_W'(1)) : rdp - POS_W'(1);
    assign is_post   = (r_req == REQ_POST_BACK) || (r_req == REQ_POST_FRONT);

    assign cap_off = i_cfg_index - CFG_CAP_BASE;
    assign cap_sel = (i_cfg_index >= CFG_CAP_BASE) &&
                     (i_cfg_index < CFG_CAP_BASE + CFG_IDX_W'(QUEUE_COUNT));
    assign cap_q   = cap_off[QIDX_W-1:0];

    always_comb begin
        n_status   = ST_OK;
        n_occ      = occ;
        n_rdp      = rdp;
        n_wrp      = wrp;
        mem_we     = 1'b0;
        mem_wr_pos = wrp;
        take_ok    = 1'b0;
        priority if (is_post && (r_msg == '0)) begin
            n_status = ST_NULL_OR_OFF;
        end else if ((r_req <= REQ_FLUSH) && !r_enable[q]) begin
            n_status = ST_NULL_OR_OFF;
        end else if (is_post) begin
            if (occ >= cap) begin
                n_status = ST_FULL;
            end else if (r_req == REQ_POST_BACK) begin
                mem_we     = 1'b1;
                mem_wr_pos = wrp;
                n_wrp      = (wr_inc >= cap) ? '0 : wr_inc[POS_W-1:0];
                n_occ      = occ + CNT_W'(1);
            end else begin
                mem_we     = 1'b1;
                mem_wr_pos = front_pos;
                n_rdp      = front_pos;
                n_occ      = occ + CNT_W'(1);
            end
        end else if (r_req == REQ_TAKE) begin
            if (occ == '0) begin
                n_status = ST_EMPTY;
            end else begin
                take_ok = 1'b1;
                n_rdp   = (rd_inc >= cap) ? '0 : rd_inc[POS_W-1:0];
                n_occ   = occ - CNT_W'(1);
            end
        end else if (r_req == REQ_FLUSH) begin
            n_occ = '0;
            n_rdp = '0;
            n_wrp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_cap[i]    <= '0;
                r_rd_pos[i] <= '0;
                r_wr_pos[i] <= '0;
                r_occ[i]    <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ENABLE) begin
                r_enable <= i_cfg_data[QUEUE_COUNT-1:0];
            end else if (cap_sel) begin
                r_cap[cap_q]    <= i_cfg_data;
                r_rd_pos[cap_q] <= '0;
                r_wr_pos[cap_q] <= '0;
                r_occ[cap_q]    <= '0;
            end
        end else if (i_cmd.exec && !bad_index) begin
            r_rd_pos[q] <= n_rdp;
            r_wr_pos[q] <= n_wrp;
            r_occ[q]    <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_qin <= i_queue_index;
            r_msg <= i_message_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !bad_index && mem_we) begin
            r_mem[{q, mem_wr_pos}] <= r_msg;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[{q, rdp}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (bad_index) begin
                r_res_status <= ST_BAD_INDEX;
                r_res_count  <= '0;
                r_res_take   <= 1'b0;
            end else begin
                r_res_status <= n_status;
                r_res_count  <= n_occ;
                r_res_take   <= take_ok;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_msg    <= r_res_take ? r_rd_data : '0;
            r_out_count  <= r_res_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_message_out = r_out_msg;
    assign o_entry_count = r_out_count;

`ifndef SYNTHESIS
    a_occ_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !bad_index) |-> (occ <= cap))
        else $error("Queue occupancy exceeds its capacity.");
    a_push_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> o_out_valid)
        else $error("Pushed result is not presented.");
    a_fail_no_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_message_out == '0))
        else $error("Failed request returns a message.");
    a_bad_index_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_BAD_INDEX)) |-> (o_entry_count == '0))
        else $error("Invalid index returns a nonzero count.");
`endif

endmodule

@@ hdl/multi_queue_message_deque_core.sv @@
// Top level of the multi-queue message deque.
// Depends on mqmd_pkg, mqmd_ctrl and mqmd_datapath.
//
// Four ring-buffer message queues of up to 16 entries share one 64-word
// message store. Each request (post back, post front, take, flush, query)
// returns one item with a status, the message taken and the count afterward.
// A request passes the execute state (store access, pointer and count
// update) and the done state, where the registered store read reaches the
// result register. A new item is accepted in the cycle its predecessor's
// result is loaded, so items pass without an idle state while the result
// side keeps up. Configuration writes take effect at once and must be made
// while the block is idle; writing a capacity register empties that queue.
module multi_queue_message_deque_core
    import mqmd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [QIN_W-1:0]         i_queue_index,
    input  logic [MESSAGE_WIDTH-1:0] i_message_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [MESSAGE_WIDTH-1:0] o_message_out,
    output logic [CNT_W-1:0]         o_entry_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mqmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mqmd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_queue_index (i_queue_index),
        .i_message_in  (i_message_in),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_message_out (o_message_out),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ tb/tb_multi_queue_message_deque_core.sv @@
// Self-checking testbench for multi_queue_message_deque_core: a directed table, then random
// requests under three idle patterns, each result checked against a behavioral deque model.
// Depends on mqmd_pkg and the RTL of multi_queue_message_deque_core.
module tb_multi_queue_message_deque_core;
    import mqmd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 584;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [MESSAGE_WIDTH-1:0] msg;
        logic [CNT_W-1:0]         cnt;
    } t_result;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     cfg_index;
        logic [CFG_DATA_W-1:0]    cfg_data;
        logic [REQ_W-1:0]         req;
        logic [QIN_W-1:0]         qi;
        logic [MESSAGE_WIDTH-1:0] msg;
        bit                       typed;
        t_result                  res;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [REQ_W-1:0]         i_req_type;
    logic [QIN_W-1:0]         i_queue_index;
    logic [MESSAGE_WIDTH-1:0] i_message_in;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [STATUS_W-1:0]      o_status;
    logic [MESSAGE_WIDTH-1:0] o_message_out;
    logic [CNT_W-1:0]         o_entry_count;

    multi_queue_message_deque_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_queue_index (i_queue_index),
        .i_message_in  (i_message_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_message_out (o_message_out),
        .o_entry_count (o_entry_count)
    );

    always #6 i_clk = ~i_clk;

    // Model state of the deque.
    logic [QUEUE_COUNT-1:0]   en_mask;
    int                       cap_reg  [QUEUE_COUNT];
    int                       rd_pos   [QUEUE_COUNT];
    int                       wr_pos   [QUEUE_COUNT];
    int                       occ      [QUEUE_COUNT];
    logic [MESSAGE_WIDTH-1:0] msg_mem  [MEM_DEPTH];

    t_result pending_results[$];
    t_row    dir_table[$];
    int      err_cnt;
    int      stall_cnt;
    int      in_idle_pct;
    int      out_idle_pct;

    function automatic void clear_queue(int q);
        rd_pos[q] = 0;
        wr_pos[q] = 0;
        occ[q]    = 0;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int q;
        if (idx == CFG_ENABLE) begin
            en_mask = data[QUEUE_COUNT-1:0];
        end else if (idx >= CFG_CAP_BASE && idx < CFG_CAP_BASE + QUEUE_COUNT) begin
            q = int'(idx - CFG_CAP_BASE);
            cap_reg[q] = int'(data);
            clear_queue(q);
        end
    endfunction

    function automatic t_result deque_predict(logic [REQ_W-1:0] req, logic [QIN_W-1:0] qi,
                                              logic [MESSAGE_WIDTH-1:0] m);
        t_result r;
        int      q;
        int      cap;
        bit      post;
        r = '0;
        r.status = ST_OK;
        if (qi >= QUEUE_COUNT) begin
            r.status = ST_BAD_INDEX;
            return r;
        end
        q    = int'(qi);
        cap  = (cap_reg[q] > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_reg[q];
        post = (req == REQ_POST_BACK) || (req == REQ_POST_FRONT);
        if (post && m == '0) begin
            r.status = ST_NULL_OR_OFF;
        end else if (req <= REQ_FLUSH && !en_mask[q]) begin
            r.status = ST_NULL_OR_OFF;
        end else if (post) begin
            if (occ[q] >= cap) begin
                r.status = ST_FULL;
            end else if (req == REQ_POST_BACK) begin
                msg_mem[ADDR_W'(q * QUEUE_DEPTH + wr_pos[q])] = m;
                wr_pos[q]++;
                if (wr_pos[q] >= cap) wr_pos[q] = 0;
                occ[q]++;
            end else begin
                if (rd_pos[q] == 0) rd_pos[q] = cap;
                rd_pos[q]--;
                msg_mem[ADDR_W'(q * QUEUE_DEPTH + rd_pos[q])] = m;
                occ[q]++;
            end
        end else if (req == REQ_TAKE) begin
            if (occ[q] == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.msg = msg_mem[ADDR_W'(q * QUEUE_DEPTH + rd_pos[q])];
                rd_pos[q]++;
                if (rd_pos[q] >= cap) rd_pos[q] = 0;
                occ[q]--;
            end
        end else if (req == REQ_FLUSH) begin
            clear_queue(q);
        end
        r.cnt = CNT_W'(occ[q]);
        return r;
    endfunction

    function automatic t_row req_row(logic [REQ_W-1:0] req, logic [QIN_W-1:0] qi,
                                     logic [MESSAGE_WIDTH-1:0] m);
        t_row row;
        row = '{kind: ROW_REQ, cfg_index: '0, cfg_data: '0, req: req, qi: qi, msg: m,
                typed: 1'b0, res: '0};
        return row;
    endfunction

    function automatic t_row req_row_chk(logic [REQ_W-1:0] req, logic [QIN_W-1:0] qi,
                                         logic [MESSAGE_WIDTH-1:0] m,
                                         logic [STATUS_W-1:0] st, logic [CNT_W-1:0] cnt);
        t_row row;
        row = req_row(req, qi, m);
        row.typed = 1'b1;
        row.res   = '{status: st, msg: '0, cnt: cnt};
        return row;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row = req_row(REQ_QUERY, '0, '0);
        row.kind      = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_data  = data;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic send_req(input logic [REQ_W-1:0] req, input logic [QIN_W-1:0] qi,
                            input logic [MESSAGE_WIDTH-1:0] m, input bit typed,
                            input t_result typed_res);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_queue_index <= qi;
        i_message_in  <= m;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = deque_predict(req, qi, m);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_cfg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup_queues(input logic [QUEUE_COUNT-1:0] mask, input int c0, input int c1,
                                input int c2, input int c3);
        wait_idle();
        cfg_write(CFG_ENABLE, CFG_DATA_W'(mask));
        cfg_write(CFG_CAP_BASE,                   CFG_DATA_W'(c0));
        cfg_write(CFG_CAP_BASE + CFG_IDX_W'(1),   CFG_DATA_W'(c1));
        cfg_write(CFG_CAP_BASE + CFG_IDX_W'(2),   CFG_DATA_W'(c2));
        cfg_write(CFG_CAP_BASE + CFG_IDX_W'(3),   CFG_DATA_W'(c3));
    endtask

    task automatic send_random();
        logic [REQ_W-1:0]         req;
        logic [QIN_W-1:0]         qi;
        logic [MESSAGE_WIDTH-1:0] m;
        int                       roll;
        roll = $urandom_range(99);
        if (roll < 30)      req = REQ_POST_BACK;
        else if (roll < 45) req = REQ_POST_FRONT;
        else if (roll < 78) req = REQ_TAKE;
        else if (roll < 82) req = REQ_FLUSH;
        else if (roll < 92) req = REQ_QUERY;
        else                req = REQ_W'($urandom_range(7, 5));
        qi = ($urandom_range(99) < 92) ? QIN_W'($urandom_range(QUEUE_COUNT - 1))
                                       : QIN_W'($urandom_range(255, QUEUE_COUNT));
        roll = $urandom_range(99);
        if (roll < 3)      m = '0;
        else if (roll < 5) m = '1;
        else               m = MESSAGE_WIDTH'($urandom_range(65535, 1));
        send_req(req, qi, m, 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item arrived with none expected", $realtime);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_message_out !== want.msg)
                    report_mismatch("message_out", int'(o_message_out), int'(want.msg));
                if (o_entry_count !== want.cnt)
                    report_mismatch("entry_count", int'(o_entry_count), int'(want.cnt));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("tb_multi_queue_message_deque_core NOT OK");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_req_type    = '0;
        i_queue_index = '0;
        i_message_in  = '0;
        i_out_ready   = 1'b0;
        err_cnt       = 0;
        stall_cnt     = 0;
        in_idle_pct   = 12;
        out_idle_pct  = 83;
        en_mask       = '0;
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            cap_reg[q] = 0;
            clear_queue(q);
        end

        // After reset every queue is disabled with capacity zero.
        dir_table.push_back(req_row_chk(REQ_QUERY,      8'd0,   16'h0000, ST_OK,          5'd0));
        dir_table.push_back(req_row_chk(REQ_POST_BACK,  8'd0,   16'h0001, ST_NULL_OR_OFF, 5'd0));
        dir_table.push_back(req_row_chk(REQ_TAKE,       8'd3,   16'h0000, ST_NULL_OR_OFF, 5'd0));
        dir_table.push_back(req_row_chk(REQ_QUERY,      8'd255, 16'h0000, ST_BAD_INDEX,   5'd0));
        dir_table.push_back(req_row_chk(REQ_POST_BACK,  8'd4,   16'h0001, ST_BAD_INDEX,   5'd0));
        dir_table.push_back(req_row_chk(3'd7,           8'd1,   16'hFFFF, ST_OK,          5'd0));
        dir_table.push_back(cfg_row(CFG_ENABLE, 5'h0F));
        dir_table.push_back(cfg_row(CFG_CAP_BASE,                 5'd16));
        dir_table.push_back(cfg_row(CFG_CAP_BASE + CFG_IDX_W'(1), 5'd0));
        dir_table.push_back(cfg_row(CFG_CAP_BASE + CFG_IDX_W'(2), 5'd31));
        dir_table.push_back(cfg_row(CFG_CAP_BASE + CFG_IDX_W'(3), 5'd2));
        dir_table.push_back(cfg_row(3'd7, 5'd31));
        dir_table.push_back(req_row_chk(REQ_POST_BACK,  8'd0,   16'h0000, ST_NULL_OR_OFF, 5'd0));
        dir_table.push_back(req_row_chk(REQ_POST_FRONT, 8'd2,   16'h0000, ST_NULL_OR_OFF, 5'd0));
        dir_table.push_back(req_row(REQ_POST_BACK,  8'd0, 16'hFFFF));
        dir_table.push_back(req_row(REQ_POST_FRONT, 8'd0, 16'h0001));
        dir_table.push_back(req_row(REQ_POST_BACK,  8'd0, 16'h8000));
        dir_table.push_back(req_row(REQ_TAKE,       8'd0, 16'h0000));
        dir_table.push_back(req_row(REQ_QUERY,      8'd0, 16'h0000));
        dir_table.push_back(req_row_chk(REQ_POST_BACK,  8'd1,   16'h1234, ST_FULL,        5'd0));
        dir_table.push_back(req_row_chk(REQ_TAKE,       8'd1,   16'h0000, ST_EMPTY,       5'd0));
        dir_table.push_back(req_row(REQ_POST_BACK,  8'd3, 16'hAAAA));
        dir_table.push_back(req_row(REQ_POST_FRONT, 8'd3, 16'h5555));
        dir_table.push_back(req_row_chk(REQ_POST_BACK,  8'd3,   16'h0F0F, ST_FULL,        5'd2));
        dir_table.push_back(req_row(REQ_TAKE,       8'd3, 16'h0000));
        dir_table.push_back(req_row(REQ_TAKE,       8'd3, 16'h0000));
        dir_table.push_back(req_row_chk(REQ_TAKE,       8'd3,   16'h0000, ST_EMPTY,       5'd0));
        dir_table.push_back(req_row(REQ_POST_BACK,  8'd2, 16'h7FFF));
        dir_table.push_back(req_row_chk(REQ_FLUSH,      8'd2,   16'h0000, ST_OK,          5'd0));
        dir_table.push_back(req_row_chk(REQ_TAKE,       8'd2,   16'h0000, ST_EMPTY,       5'd0));
        dir_table.push_back(req_row_chk(REQ_FLUSH,      8'd0,   16'h0000, ST_OK,          5'd0));
        dir_table.push_back(req_row(REQ_QUERY,      8'd0, 16'h0000));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_table[i].cfg_index, dir_table[i].cfg_data);
            end else begin
                send_req(dir_table[i].req, dir_table[i].qi, dir_table[i].msg,
                         dir_table[i].typed, dir_table[i].res);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  = 12;
                    out_idle_pct = 83;
                    setup_queues(4'hF, 16, 31, 1, 5);
                end
                1: begin
                    in_idle_pct  = 83;
                    out_idle_pct = 12;
                    setup_queues(4'b0101, 0, 16, 3, 8);
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                    setup_queues(4'b1011, 7, 2, 16, 31);
                end
            endcase
            repeat (PHASE_ITEMS) send_random();
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("tb_multi_queue_message_deque_core OK");
        end else begin
            $display("tb_multi_queue_message_deque_core NOT OK");
        end
        $finish;
    end

endmodule
